>>> hw/rtl/drrip_pkg.sv
// ----------------------------------------------------------------------------
// drrip_pkg: shared types and constants
// Default geometry, field widths, register indexes and the codes that the
// front, back and top level of the replacement engine all use.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package drrip_pkg;

  // Default geometry
  localparam int NUM_SETS_DEF     = 2048;
  localparam int NUM_WAYS_DEF     = 16;
  localparam int SIG_BITS_DEF     = 6;
  localparam int SEL_BITS_DEF     = 10;
  localparam int LEADERS_EACH_DEF = 32;

  // Fixed field widths
  localparam int SET_IN_W  = 11;
  localparam int WAY_IN_W  = 4;
  localparam int PC_W      = 6;
  localparam int WAY_OUT_W = 4;

  // Global counters and decay epoch
  localparam int ACC_W   = 20;
  localparam int BIM_W   = 10;
  localparam int EPOCH_W = 32;

  // Configuration registers
  localparam int DECAY_W = 5;
  localparam int BRRIP_W = 4;
  localparam int ADDR_W  = 3;
  localparam int DATA_W  = 32;
  localparam logic [DECAY_W-1:0] DECAY_RESET = 5'd12;
  localparam logic [BRRIP_W-1:0] BRRIP_RESET = 4'd5;
  localparam logic REG_DECAY = 1'b0;
  localparam logic REG_BRRIP = 1'b1;

  // Two-bit counters
  localparam logic [1:0] CNT_MAX  = 2'd3;
  localparam logic [1:0] CNT_ZERO = 2'd0;
  localparam logic [1:0] REUSE_HOT = 2'd2;

  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    REASON_HIT  = 2'd0,
    REASON_DEAD = 2'd1,
    REASON_RRPV = 2'd2
  } reason_t;

  typedef enum logic [1:0] {
    LEAD_FOLLOW = 2'd0,
    LEAD_SRRIP  = 2'd1,
    LEAD_BRRIP  = 2'd2
  } leader_t;

endpackage

`default_nettype wire

>>> hw/rtl/drrip_ram.sv
// ----------------------------------------------------------------------------
// drrip_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module drrip_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> hw/rtl/drrip_front.sv
// ----------------------------------------------------------------------------
// drrip_front: access intake and classification
// Folds set and way into range, forms the signature and tags leader sets.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module drrip_front #(
  parameter int NUM_SETS     = drrip_pkg::NUM_SETS_DEF,
  parameter int NUM_WAYS     = drrip_pkg::NUM_WAYS_DEF,
  parameter int SIG_BITS     = drrip_pkg::SIG_BITS_DEF,
  parameter int LEADERS_EACH = drrip_pkg::LEADERS_EACH_DEF
) (
  input  wire logic                            in_valid,
  output      logic                            in_stall,
  input  wire logic [drrip_pkg::SET_IN_W-1:0]  set,
  input  wire logic                            hit,
  input  wire logic [drrip_pkg::WAY_IN_W-1:0]  hit_way,
  input  wire logic [drrip_pkg::PC_W-1:0]      pc_bits,
  input  wire logic [drrip_pkg::PC_W-1:0]      line_addr_bits,
  input  wire logic                            q_full,
  output      logic                            q_push,
  output      logic [$clog2(NUM_SETS)-1:0]     set_idx,
  output      logic                            hit_flag,
  output      logic [$clog2(NUM_WAYS)-1:0]     way_idx,
  output      logic [SIG_BITS-1:0]             sig,
  output      drrip_pkg::leader_t              leader
);

  localparam int SET_W = $clog2(NUM_SETS);
  localparam int WAY_W = $clog2(NUM_WAYS);
  localparam int IW    = drrip_pkg::SET_IN_W;

  // Restoring reduction by a constant; quotient stays below 32 for all
  // legal geometries, so five compare-subtract steps suffice.
  function automatic logic [IW-1:0] reduce(input logic [IW-1:0] v, input int unsigned m);
    logic [IW-1:0] r;
    r = v;
    for (int k = 4; k >= 0; k--) begin
      if (32'(r) >= (m << k)) begin
        r = r - IW'(m << k);
      end
    end
    return r;
  endfunction

  logic [IW-1:0] set_red;
  logic [IW-1:0] way_red;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;
  assign hit_flag = hit;

  always_comb begin
    set_red = reduce(set, NUM_SETS);
    way_red = reduce(IW'(hit_way), NUM_WAYS);
    set_idx = SET_W'(set_red);
    way_idx = WAY_W'(way_red);
    sig     = SIG_BITS'(pc_bits ^ line_addr_bits);
    if (32'(set_idx) < LEADERS_EACH) begin
      leader = drrip_pkg::LEAD_SRRIP;
    end else if (32'(set_idx) < 2 * LEADERS_EACH) begin
      leader = drrip_pkg::LEAD_BRRIP;
    end else begin
      leader = drrip_pkg::LEAD_FOLLOW;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/drrip_queue.sv
// ----------------------------------------------------------------------------
// drrip_queue: short decoupling FIFO
// Holds classified accesses between the front and the back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module drrip_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = drrip_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output      logic             full,
  input  wire logic             pop,
  output      logic [WIDTH-1:0] pop_data,
  output      logic             not_empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entry [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign pop_data  = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        entry[wr_ptr] <= push_data;
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/drrip_back.sv
// ----------------------------------------------------------------------------
// drrip_back: replacement engine
// Read-modify-write of one set row per access, predictor training, selector
// and global counters, plus the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module drrip_back #(
  parameter int NUM_SETS = drrip_pkg::NUM_SETS_DEF,
  parameter int NUM_WAYS = drrip_pkg::NUM_WAYS_DEF,
  parameter int SIG_BITS = drrip_pkg::SIG_BITS_DEF,
  parameter int SEL_BITS = drrip_pkg::SEL_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              q_valid,
  output      logic                              q_pop,
  input  wire logic [$clog2(NUM_SETS)-1:0]       q_set,
  input  wire logic                              q_hit,
  input  wire logic [$clog2(NUM_WAYS)-1:0]       q_way,
  input  wire logic [SIG_BITS-1:0]               q_sig,
  input  wire drrip_pkg::leader_t                q_leader,
  input  wire logic [drrip_pkg::DECAY_W-1:0]     decay_log2,
  input  wire logic [drrip_pkg::BRRIP_W-1:0]     brrip_log2,
  output      logic                              out_valid,
  input  wire logic                              out_stall,
  output      logic [drrip_pkg::WAY_OUT_W-1:0]   way,
  output      drrip_pkg::reason_t                victim_reason
);

  localparam int SET_W   = $clog2(NUM_SETS);
  localparam int WAY_W   = $clog2(NUM_WAYS);
  localparam int SIG_N   = 1 << SIG_BITS;
  localparam int EW      = drrip_pkg::EPOCH_W;
  localparam int ACC_W   = drrip_pkg::ACC_W;
  localparam int BIM_W   = drrip_pkg::BIM_W;
  localparam int WO      = drrip_pkg::WAY_OUT_W;
  localparam int RR_OFF  = 0;
  localparam int DC_OFF  = 2 * NUM_WAYS;
  localparam int SG_OFF  = 4 * NUM_WAYS;
  localparam int EP_OFF  = SG_OFF + SIG_BITS * NUM_WAYS;
  localparam int ROW_W   = EP_OFF + EW;
  localparam int CLR_N   = (NUM_SETS > SIG_N) ? NUM_SETS : SIG_N;
  localparam int CLR_W   = $clog2(CLR_N);
  localparam logic [SEL_BITS-1:0] SEL_MID = SEL_BITS'(1) << (SEL_BITS - 1);
  localparam logic [SEL_BITS-1:0] SEL_MAX = '1;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EVAL1,
    S_EVAL2,
    S_TRAIN,
    S_DONE
  } state_t;

  typedef logic [NUM_WAYS-1:0][1:0]          cnt_row_t;
  typedef logic [NUM_WAYS-1:0][SIG_BITS-1:0] sig_row_t;

  state_t state;
  logic [CLR_W-1:0] clr_cnt;

  // Current access
  logic [SET_W-1:0]    c_set;
  logic                c_hit;
  logic [WAY_W-1:0]    c_way;
  logic [SIG_BITS-1:0] c_sig;
  drrip_pkg::leader_t  c_leader;

  // Row after victim choice
  cnt_row_t            r_rrpv;
  cnt_row_t            r_dead;
  sig_row_t            r_sigs;
  logic [WAY_W-1:0]    r_way;
  drrip_pkg::reason_t  r_reason;
  logic [1:0]          r_reuse;
  logic [SIG_BITS-1:0] r_old_sig;

  // Globals
  logic [EW-1:0]       epoch;
  logic [ACC_W-1:0]    acc_cnt;
  logic [BIM_W-1:0]    bim_cnt;
  logic [SEL_BITS-1:0] selector;

  // Memory ports
  logic                row_we;
  logic [SET_W-1:0]    row_waddr;
  logic [ROW_W-1:0]    row_wdata;
  logic [ROW_W-1:0]    row_rdata;
  logic                reuse_we;
  logic [SIG_BITS-1:0] reuse_waddr;
  logic [1:0]          reuse_wdata;
  logic [SIG_BITS-1:0] reuse_raddr;
  logic [1:0]          reuse_rdata;

  // Victim choice
  cnt_row_t            rd_rrpv;
  cnt_row_t            rd_dead;
  cnt_row_t            eff_dead;
  cnt_row_t            dec_dead;
  cnt_row_t            aged;
  logic [EW-1:0]       age_diff;
  logic [1:0]          lag;
  logic [1:0]          top;
  logic                dead_found;
  logic [WAY_W-1:0]    dead_way;
  logic [WAY_W-1:0]    rrpv_way;
  logic [ACC_W-1:0]    acc_next;
  logic [ACC_W-1:0]    acc_mask;
  logic                decay;

  // Update
  cnt_row_t            new_rrpv;
  cnt_row_t            new_dead;
  sig_row_t            new_sigs;
  logic [1:0]          blk_dead;
  logic [1:0]          ins;
  logic                use_srrip;
  logic                bim_step;
  logic [BIM_W-1:0]    bim_next;
  logic [BIM_W-1:0]    bim_mask;
  logic [SEL_BITS-1:0] sel_next;
  logic                out_free;
  logic                start;

  drrip_ram #(.WIDTH(ROW_W), .DEPTH(NUM_SETS)) u_row_ram (
    .clk   (clk),
    .we    (row_we),
    .waddr (row_waddr),
    .wdata (row_wdata),
    .raddr (q_set),
    .rdata (row_rdata)
  );

  drrip_ram #(.WIDTH(2), .DEPTH(SIG_N)) u_reuse_ram (
    .clk   (clk),
    .we    (reuse_we),
    .waddr (reuse_waddr),
    .wdata (reuse_wdata),
    .raddr (reuse_raddr),
    .rdata (reuse_rdata)
  );

  assign out_free = !out_valid || !out_stall;
  assign start    = q_valid && ((state == S_IDLE) || ((state == S_DONE) && out_free));
  assign q_pop    = start;

  // Victim choice on the row just read
  always_comb begin
    rd_rrpv  = cnt_row_t'(row_rdata[RR_OFF +: 2 * NUM_WAYS]);
    rd_dead  = cnt_row_t'(row_rdata[DC_OFF +: 2 * NUM_WAYS]);
    age_diff = epoch - row_rdata[EP_OFF +: EW];
    lag      = (age_diff >= EW'(3)) ? drrip_pkg::CNT_MAX : age_diff[1:0];
    acc_next = acc_cnt + 1'b1;
    acc_mask = (32'(decay_log2) >= ACC_W) ? '1 : ACC_W'((32'd1 << decay_log2) - 32'd1);
    decay    = ((acc_next & acc_mask) == '0);
    top      = drrip_pkg::CNT_ZERO;
    for (int i = 0; i < NUM_WAYS; i++) begin
      eff_dead[i] = (rd_dead[i] > lag) ? rd_dead[i] - lag : drrip_pkg::CNT_ZERO;
      dec_dead[i] = (decay && eff_dead[i] != drrip_pkg::CNT_ZERO) ?
                    eff_dead[i] - 2'd1 : eff_dead[i];
      if (rd_rrpv[i] > top) begin
        top = rd_rrpv[i];
      end
    end
    dead_found = 1'b0;
    dead_way   = '0;
    rrpv_way   = '0;
    for (int i = NUM_WAYS - 1; i >= 0; i--) begin
      aged[i] = rd_rrpv[i] + (drrip_pkg::CNT_MAX - top);
      if (eff_dead[i] == drrip_pkg::CNT_MAX) begin
        dead_found = 1'b1;
        dead_way   = WAY_W'(i);
      end
      if (aged[i] == drrip_pkg::CNT_MAX) begin
        rrpv_way = WAY_W'(i);
      end
    end
  end

  // Insertion and row update
  always_comb begin
    new_rrpv  = r_rrpv;
    new_dead  = r_dead;
    new_sigs  = r_sigs;
    blk_dead  = r_dead[r_way];
    bim_next  = bim_cnt + 1'b1;
    bim_mask  = (32'(brrip_log2) >= BIM_W) ? '1 : BIM_W'((32'd1 << brrip_log2) - 32'd1);
    bim_step  = 1'b0;
    ins       = drrip_pkg::CNT_MAX;
    sel_next  = selector;
    case (c_leader)
      drrip_pkg::LEAD_SRRIP: use_srrip = 1'b1;
      drrip_pkg::LEAD_BRRIP: use_srrip = 1'b0;
      default:               use_srrip = (selector >= SEL_MID);
    endcase
    new_sigs[r_way] = c_sig;
    if (c_hit) begin
      new_rrpv[r_way] = drrip_pkg::CNT_ZERO;
      new_dead[r_way] = drrip_pkg::CNT_ZERO;
    end else begin
      if (blk_dead != drrip_pkg::CNT_MAX) begin
        if (r_reuse >= drrip_pkg::REUSE_HOT) begin
          ins = drrip_pkg::CNT_ZERO;
        end else if (!use_srrip) begin
          bim_step = 1'b1;
          if ((bim_next & bim_mask) == '0) begin
            ins = drrip_pkg::CNT_ZERO;
          end
        end
      end
      new_rrpv[r_way] = ins;
      new_dead[r_way] = (blk_dead != drrip_pkg::CNT_MAX) ? blk_dead + 2'd1 : blk_dead;
      if (c_leader == drrip_pkg::LEAD_SRRIP && selector != '0) begin
        sel_next = selector - 1'b1;
      end else if (c_leader == drrip_pkg::LEAD_BRRIP && selector != SEL_MAX) begin
        sel_next = selector + 1'b1;
      end
    end
  end

  // Memory write and read address steering
  always_comb begin
    row_we      = 1'b0;
    row_waddr   = c_set;
    row_wdata   = {epoch, new_sigs, new_dead, new_rrpv};
    reuse_we    = 1'b0;
    reuse_waddr = c_sig;
    reuse_wdata = (r_reuse != drrip_pkg::CNT_MAX) ? r_reuse + 2'd1 : r_reuse;
    reuse_raddr = (state == S_EVAL2) ? r_sigs[r_way] : q_sig;
    case (state)
      S_CLEAR: begin
        row_we      = (32'(clr_cnt) < NUM_SETS);
        row_waddr   = SET_W'(clr_cnt);
        row_wdata   = {{EW{1'b0}}, {(SIG_BITS * NUM_WAYS){1'b0}},
                       {(2 * NUM_WAYS){1'b0}}, {(2 * NUM_WAYS){1'b1}}};
        reuse_we    = (32'(clr_cnt) < SIG_N);
        reuse_waddr = SIG_BITS'(clr_cnt);
        reuse_wdata = drrip_pkg::CNT_ZERO;
      end
      S_EVAL2: begin
        row_we   = 1'b1;
        reuse_we = c_hit;
      end
      S_TRAIN: begin
        reuse_we    = 1'b1;
        reuse_waddr = r_old_sig;
        reuse_wdata = (reuse_rdata != drrip_pkg::CNT_ZERO) ? reuse_rdata - 2'd1 : reuse_rdata;
      end
      default: begin
        row_we   = 1'b0;
        reuse_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      epoch     <= '0;
      acc_cnt   <= '0;
      bim_cnt   <= '0;
      selector  <= SEL_MID;
      out_valid <= 1'b0;
    end else begin
      // Drop a taken result; the done state loads the next one itself
      if (out_valid && !out_stall && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      if (start) begin
        c_set    <= q_set;
        c_hit    <= q_hit;
        c_way    <= q_way;
        c_sig    <= q_sig;
        c_leader <= q_leader;
      end
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == CLR_W'(CLR_N - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            state <= S_EVAL1;
          end
        end
        S_EVAL1: begin
          // Choose the way, age on an RRPV miss, apply any decay
          r_dead  <= dec_dead;
          r_sigs  <= sig_row_t'(row_rdata[SG_OFF +: SIG_BITS * NUM_WAYS]);
          r_reuse <= reuse_rdata;
          acc_cnt <= acc_next;
          epoch   <= epoch + EW'(decay);
          if (c_hit) begin
            r_way    <= c_way;
            r_reason <= drrip_pkg::REASON_HIT;
            r_rrpv   <= rd_rrpv;
          end else if (dead_found) begin
            r_way    <= dead_way;
            r_reason <= drrip_pkg::REASON_DEAD;
            r_rrpv   <= rd_rrpv;
          end else begin
            r_way    <= rrpv_way;
            r_reason <= drrip_pkg::REASON_RRPV;
            r_rrpv   <= aged;
          end
          state <= S_EVAL2;
        end
        S_EVAL2: begin
          r_old_sig <= r_sigs[r_way];
          selector  <= sel_next;
          if (bim_step) begin
            bim_cnt <= bim_next;
          end
          state <= c_hit ? S_DONE : S_TRAIN;
        end
        S_TRAIN: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_valid     <= 1'b1;
            way           <= WO'(r_way);
            victim_reason <= r_reason;
            state         <= start ? S_EVAL1 : S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/drrip_ship_deadblock_replacement.sv
// ----------------------------------------------------------------------------
// drrip_ship_deadblock_replacement: DRRIP + SHiP + dead-block replacement
// Victim selection and replacement state for a set-associative cache.
// ----------------------------------------------------------------------------
// Each accepted access returns one transfer on the output channel: the hit
// way, or the victim way on a miss with the reason it was chosen. The
// engine reads, updates and writes back the per-set row memory once per
// access, and a miss adds one more predictor-table read and write for the
// evicted signature. The front stage and a two-entry queue keep taking
// accesses while the engine works, and a finished result waits in the
// output register without blocking the next access. The global decay of
// dead counters costs nothing: each row records the decay epoch it was
// last written in, and the lag is folded in when the row is next read.
// After reset a clearing pass initializes the row and predictor memories;
// accesses wait, configuration writes are taken as usual.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module drrip_ship_deadblock_replacement #(
  parameter int NUM_SETS     = drrip_pkg::NUM_SETS_DEF,
  parameter int NUM_WAYS     = drrip_pkg::NUM_WAYS_DEF,
  parameter int SIG_BITS     = drrip_pkg::SIG_BITS_DEF,
  parameter int SEL_BITS     = drrip_pkg::SEL_BITS_DEF,
  parameter int LEADERS_EACH = drrip_pkg::LEADERS_EACH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // Access channel
  input  wire logic                              in_valid,
  output      logic                              in_stall,
  input  wire logic [drrip_pkg::SET_IN_W-1:0]    set,
  input  wire logic                              hit,
  input  wire logic [drrip_pkg::WAY_IN_W-1:0]    hit_way,
  input  wire logic [drrip_pkg::PC_W-1:0]        pc_bits,
  input  wire logic [drrip_pkg::PC_W-1:0]        line_addr_bits,
  // Result channel
  output      logic                              out_valid,
  input  wire logic                              out_stall,
  output      logic [drrip_pkg::WAY_OUT_W-1:0]   way,
  output      logic [1:0]                        victim_reason,
  // Configuration port
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [drrip_pkg::ADDR_W-1:0]      paddr,
  input  wire logic [drrip_pkg::DATA_W-1:0]      pwdata,
  output      logic [drrip_pkg::DATA_W-1:0]      prdata,
  output      logic                              pready
);

  localparam int SET_W = $clog2(NUM_SETS);
  localparam int WAY_W = $clog2(NUM_WAYS);
  localparam int ENT_W = 2 + 1 + SET_W + WAY_W + SIG_BITS;
  localparam int DW    = drrip_pkg::DATA_W;

  // Configuration registers
  logic [drrip_pkg::DECAY_W-1:0] decay_log2;
  logic [drrip_pkg::BRRIP_W-1:0] brrip_log2;

  // Front outputs
  logic                 q_push;
  logic                 q_full;
  logic [SET_W-1:0]     f_set;
  logic                 f_hit;
  logic [WAY_W-1:0]     f_way;
  logic [SIG_BITS-1:0]  f_sig;
  drrip_pkg::leader_t   f_leader;

  // Queue outputs
  logic [ENT_W-1:0]     q_data;
  logic                 q_valid;
  logic                 q_pop;
  drrip_pkg::reason_t   reason;

  assign pready        = 1'b1;
  assign victim_reason = reason;

  // Register writes complete in the access phase; pready never holds off
  always_ff @(posedge clk) begin
    if (rst) begin
      decay_log2 <= drrip_pkg::DECAY_RESET;
      brrip_log2 <= drrip_pkg::BRRIP_RESET;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        drrip_pkg::REG_DECAY: decay_log2 <= pwdata[drrip_pkg::DECAY_W-1:0];
        drrip_pkg::REG_BRRIP: brrip_log2 <= pwdata[drrip_pkg::BRRIP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      drrip_pkg::REG_DECAY: prdata = DW'(decay_log2);
      drrip_pkg::REG_BRRIP: prdata = DW'(brrip_log2);
      default:              prdata = '0;
    endcase
  end

  // Classify the access: fold into range, form signature, tag leaders
  drrip_front #(
    .NUM_SETS     (NUM_SETS),
    .NUM_WAYS     (NUM_WAYS),
    .SIG_BITS     (SIG_BITS),
    .LEADERS_EACH (LEADERS_EACH)
  ) u_front (
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .set            (set),
    .hit            (hit),
    .hit_way        (hit_way),
    .pc_bits        (pc_bits),
    .line_addr_bits (line_addr_bits),
    .q_full         (q_full),
    .q_push         (q_push),
    .set_idx        (f_set),
    .hit_flag       (f_hit),
    .way_idx        (f_way),
    .sig            (f_sig),
    .leader         (f_leader)
  );

  // Decouple intake from the engine
  drrip_queue #(
    .WIDTH (ENT_W),
    .DEPTH (drrip_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data ({f_leader, f_hit, f_set, f_way, f_sig}),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_data),
    .not_empty (q_valid)
  );

  // Carry out victim choice and state update, hold the result
  drrip_back #(
    .NUM_SETS (NUM_SETS),
    .NUM_WAYS (NUM_WAYS),
    .SIG_BITS (SIG_BITS),
    .SEL_BITS (SEL_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_pop         (q_pop),
    .q_set         (q_data[WAY_W + SIG_BITS +: SET_W]),
    .q_hit         (q_data[SET_W + WAY_W + SIG_BITS]),
    .q_way         (q_data[SIG_BITS +: WAY_W]),
    .q_sig         (q_data[SIG_BITS-1:0]),
    .q_leader      (drrip_pkg::leader_t'(q_data[ENT_W-1 -: 2])),
    .decay_log2    (decay_log2),
    .brrip_log2    (brrip_log2),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .way           (way),
    .victim_reason (reason)
  );

endmodule

`default_nettype wire

>>> sim/drrip_replacement_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drrip_replacement_checker: victim predictor and result scoreboard
// Watches the access, result and configuration channels, mirrors the
// replacement state and compares every result transfer with its prediction.
// ----------------------------------------------------------------------------
module drrip_replacement_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  input  logic                             in_stall,
  input  logic [drrip_pkg::SET_IN_W-1:0]   set,
  input  logic                             hit,
  input  logic [drrip_pkg::WAY_IN_W-1:0]   hit_way,
  input  logic [drrip_pkg::PC_W-1:0]       pc_bits,
  input  logic [drrip_pkg::PC_W-1:0]       line_addr_bits,
  input  logic                             out_valid,
  input  logic                             out_stall,
  input  logic [drrip_pkg::WAY_OUT_W-1:0]  way,
  input  logic [1:0]                       victim_reason,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [drrip_pkg::ADDR_W-1:0]     paddr,
  input  logic [drrip_pkg::DATA_W-1:0]     pwdata,
  input  logic                             pready,
  output int                               fail_count,
  output int                               pending
);

  localparam int SETS    = drrip_pkg::NUM_SETS_DEF;
  localparam int WAYS    = drrip_pkg::NUM_WAYS_DEF;
  localparam int BLOCKS  = SETS * WAYS;
  localparam int SIG_W   = drrip_pkg::SIG_BITS_DEF;
  localparam int SIGS    = 1 << SIG_W;
  localparam int SEL_MAX = (1 << drrip_pkg::SEL_BITS_DEF) - 1;
  localparam int SEL_MID = 1 << (drrip_pkg::SEL_BITS_DEF - 1);
  localparam int SET_W   = drrip_pkg::SET_IN_W;
  localparam int WIN_W   = drrip_pkg::WAY_IN_W;
  localparam int PCW     = drrip_pkg::PC_W;
  localparam int WO      = drrip_pkg::WAY_OUT_W;
  localparam int DECW    = drrip_pkg::DECAY_W;
  localparam int BRW     = drrip_pkg::BRRIP_W;

  typedef struct packed {
    logic [WO-1:0]      way;
    drrip_pkg::reason_t reason;
  } victim_t;

  victim_t                     victim_q[$];
  logic [1:0]                  rrpv_mem[BLOCKS];
  logic [1:0]                  dead_mem[BLOCKS];
  logic [SIG_W-1:0]            sig_mem[BLOCKS];
  logic [1:0]                  reuse_ctr[SIGS];
  int unsigned                 selector;
  logic [drrip_pkg::ACC_W-1:0] access_ctr;
  logic [drrip_pkg::BIM_W-1:0] bimodal_ctr;
  logic [DECW-1:0]             decay_log2;
  logic [BRW-1:0]              brrip_log2;

  initial begin
    foreach (rrpv_mem[i]) begin
      rrpv_mem[i] = drrip_pkg::CNT_MAX;
      dead_mem[i] = drrip_pkg::CNT_ZERO;
      sig_mem[i]  = '0;
    end
    foreach (reuse_ctr[i]) reuse_ctr[i] = drrip_pkg::CNT_ZERO;
    selector    = SEL_MID;
    access_ctr  = '0;
    bimodal_ctr = '0;
    decay_log2  = drrip_pkg::DECAY_RESET;
    brrip_log2  = drrip_pkg::BRRIP_RESET;
    fail_count  = 0;
  end

  assign pending = victim_q.size();

  function automatic bit low_bits_zero(longint unsigned v, int unsigned n);
    return (v & ((64'd1 << n) - 1)) == 0;
  endfunction

  // Pick the way, update all replacement state, return the expected transfer.
  function automatic victim_t choose_victim(logic [SET_W-1:0] s, logic h,
                                            logic [WIN_W-1:0] hw,
                                            logic [PCW-1:0] pc,
                                            logic [PCW-1:0] la);
    int unsigned set_i, base, w, blk, top;
    logic [SIG_W-1:0] sig, old_sig;
    drrip_pkg::reason_t rsn;
    bit found, srrip_lead, brrip_lead, use_srrip;
    logic [1:0] ins;
    victim_t res;
    set_i = s % SETS;
    base  = set_i * WAYS;
    w     = hw % WAYS;
    sig   = SIG_W'(pc ^ la);
    rsn   = drrip_pkg::REASON_HIT;
    found = 0;
    if (!h) begin
      for (int i = 0; i < WAYS && !found; i++)
        if (dead_mem[base + i] == drrip_pkg::CNT_MAX) begin
          w = i; rsn = drrip_pkg::REASON_DEAD; found = 1;
        end
      if (!found) begin
        top = 0;
        for (int i = 0; i < WAYS; i++)
          if (rrpv_mem[base + i] > top) top = 32'(rrpv_mem[base + i]);
        for (int i = 0; i < WAYS; i++)
          rrpv_mem[base + i] = 2'(rrpv_mem[base + i] + (3 - top));
        for (int i = 0; i < WAYS && !found; i++)
          if (rrpv_mem[base + i] == drrip_pkg::CNT_MAX) begin
            w = i; found = 1;
          end
        rsn = drrip_pkg::REASON_RRPV;
      end
    end
    // global dead-counter decay
    access_ctr = access_ctr + 1'b1;
    if (low_bits_zero(access_ctr, decay_log2))
      foreach (dead_mem[i]) if (dead_mem[i] != drrip_pkg::CNT_ZERO) dead_mem[i]--;
    blk = base + w;
    if (h) begin
      sig_mem[blk] = sig;
      if (reuse_ctr[sig] != drrip_pkg::CNT_MAX) reuse_ctr[sig]++;
      rrpv_mem[blk] = drrip_pkg::CNT_ZERO;
      dead_mem[blk] = drrip_pkg::CNT_ZERO;
    end else begin
      ins = drrip_pkg::CNT_MAX;
      srrip_lead = set_i < drrip_pkg::LEADERS_EACH_DEF;
      brrip_lead = !srrip_lead && set_i < 2 * drrip_pkg::LEADERS_EACH_DEF;
      if (dead_mem[blk] != drrip_pkg::CNT_MAX) begin
        use_srrip = srrip_lead ? 1'b1 : brrip_lead ? 1'b0 : (selector >= SEL_MID);
        if (reuse_ctr[sig] >= drrip_pkg::REUSE_HOT) ins = drrip_pkg::CNT_ZERO;
        else if (!use_srrip) begin
          bimodal_ctr = bimodal_ctr + 1'b1;
          if (low_bits_zero(bimodal_ctr, brrip_log2)) ins = drrip_pkg::CNT_ZERO;
        end
      end
      rrpv_mem[blk] = ins;
      old_sig = sig_mem[blk];
      if (reuse_ctr[old_sig] != drrip_pkg::CNT_ZERO) reuse_ctr[old_sig]--;
      sig_mem[blk] = sig;
      if (dead_mem[blk] != drrip_pkg::CNT_MAX) dead_mem[blk]++;
      if (srrip_lead) begin
        if (selector > 0) selector--;
      end else if (brrip_lead) begin
        if (selector < SEL_MAX) selector++;
      end
    end
    res.way    = w[WO-1:0];
    res.reason = rsn;
    return res;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    victim_t want;
    if (!rst) begin
      if (psel && penable && pwrite && pready) begin
        if (paddr == {drrip_pkg::REG_DECAY, 2'b00}) decay_log2 = pwdata[DECW-1:0];
        else if (paddr == {drrip_pkg::REG_BRRIP, 2'b00}) brrip_log2 = pwdata[BRW-1:0];
      end
      if (in_valid && !in_stall)
        victim_q.push_back(choose_victim(set, hit, hit_way, pc_bits, line_addr_bits));
      if (out_valid && !out_stall) begin
        if (victim_q.size() == 0) begin
          $display("[%0t] result transfer with nothing expected", $realtime);
          fail_count++;
        end else begin
          want = victim_q.pop_front();
          if (way !== want.way) report_mismatch("way", way, want.way);
          if (victim_reason !== want.reason)
            report_mismatch("victim_reason", victim_reason, want.reason);
        end
      end
    end
  end

endmodule

>>> sim/tb_drrip_ship_deadblock_replacement.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_drrip_ship_deadblock_replacement: replacement engine testbench
// Drives directed and random cache accesses in bursts through several
// decay and bimodal period settings, stalls the result side at random and
// once for a long stretch, and lets the checker score every result.
// ----------------------------------------------------------------------------
module tb_drrip_ship_deadblock_replacement;

  localparam int LIMIT_CYCLES = 600000;
  localparam int PHASE_ITEMS  = 360;
  localparam int SET_W        = drrip_pkg::SET_IN_W;
  localparam int WIN_W        = drrip_pkg::WAY_IN_W;
  localparam int PCW          = drrip_pkg::PC_W;
  localparam int WO           = drrip_pkg::WAY_OUT_W;
  localparam int AW           = drrip_pkg::ADDR_W;
  localparam int DW           = drrip_pkg::DATA_W;
  localparam int DECW         = drrip_pkg::DECAY_W;
  localparam int BRW          = drrip_pkg::BRRIP_W;
  localparam int LEADS        = drrip_pkg::LEADERS_EACH_DEF;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [SET_W-1:0]  set = '0;
  logic              hit = 1'b0;
  logic [WIN_W-1:0]  hit_way = '0;
  logic [PCW-1:0]    pc_bits = '0;
  logic [PCW-1:0]    line_addr_bits = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [WO-1:0]     way;
  logic [1:0]        victim_reason;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [AW-1:0]     paddr = '0;
  logic [DW-1:0]     pwdata = '0;
  logic [DW-1:0]     prdata;
  logic              pready;
  int                fail_count;
  int                pending;
  int                cycle_count = 0;
  bit                hold_request = 0;
  logic [SET_W-1:0]  follower_sets[8];

  always #5 clk = ~clk;

  drrip_ship_deadblock_replacement DUT (.*);

  drrip_replacement_checker u_checker (.*);

  // Guard against a hung handshake.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Receiver: random stall pattern, plus one long hold-off on request so the
  // engine queue fills and pushes back on the access channel.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_request) begin
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
        hold_request = 0;
      end
      case ($urandom_range(0, 3))
        0:       out_stall <= 1'b1;
        1:       out_stall <= ($urandom_range(0, 1) == 1);
        default: out_stall <= 1'b0;
      endcase
    end
  end

  // Two-phase configuration write; the register lands on the access edge.
  task automatic write_reg(logic idx, logic [DW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Present one access and hold it until the transfer happens.
  task automatic send_access(logic [SET_W-1:0] s, logic h, logic [WIN_W-1:0] w,
                             logic [PCW-1:0] pc, logic [PCW-1:0] la);
    in_valid       <= 1'b1;
    set            <= s;
    hit            <= h;
    hit_way        <= w;
    pc_bits        <= pc;
    line_addr_bits <= la;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Drain all outstanding results, then leave the engine idle before returning.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  // Random accesses, mostly on a small pool of sets so state builds up.
  task automatic random_phase(int count);
    int burst;
    logic [SET_W-1:0] s;
    logic [PCW-1:0] pc;
    burst = $urandom_range(1, 12);
    for (int n = 0; n < count; n++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: s = SET_W'($urandom_range(0, 2 * LEADS - 1));
        4, 5, 6, 7: s = follower_sets[$urandom_range(0, 7)];
        default:    s = SET_W'($urandom());
      endcase
      // mostly a small pool of PC values (signatures mix in random line bits); trains the reuse table both ways
      pc = ($urandom_range(0, 2) != 0) ? PCW'($urandom_range(0, 7)) : PCW'($urandom());
      send_access(s, 1'($urandom_range(0, 1)), WIN_W'($urandom()), pc, PCW'($urandom()));
      if (--burst == 0) begin
        burst = $urandom_range(1, 12);
        if ($urandom_range(0, 3) != 0) begin
          in_valid <= 1'b0;
          repeat ($urandom_range(1, 8)) @(posedge clk);
        end
      end
    end
  endtask

  initial begin
    logic [DECW-1:0] decay_set[5];
    logic [BRW-1:0]  brrip_set[5];
    decay_set = '{5'd12, 5'd1, 5'd20, 5'd3, 5'd7};
    brrip_set = '{4'd5, 4'd1, 4'd10, 4'd2, 4'd4};
    foreach (follower_sets[i]) follower_sets[i] = SET_W'($urandom_range(64, 2047));
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: field extremes, leader boundaries, hits on edge ways,
    // repeated misses into one set to drive dead counters up.
    send_access(11'd0, 1'b0, 4'd0, 6'd0, 6'd0);
    send_access(11'd2047, 1'b0, 4'd15, 6'd63, 6'd63);
    send_access(11'd31, 1'b0, 4'd0, 6'd63, 6'd0);
    send_access(11'd32, 1'b0, 4'd0, 6'd0, 6'd63);
    send_access(11'd63, 1'b0, 4'd0, 6'd5, 6'd5);
    send_access(11'd64, 1'b0, 4'd0, 6'd21, 6'd42);
    send_access(11'd0, 1'b1, 4'd0, 6'd1, 6'd0);
    send_access(11'd0, 1'b1, 4'd15, 6'd1, 6'd0);
    send_access(11'd2047, 1'b1, 4'd15, 6'd63, 6'd0);
    send_access(11'd1024, 1'b1, 4'd7, 6'd1, 6'd0);
    for (int i = 0; i < 12; i++)
      send_access(11'd100, 1'b0, 4'd0, 6'(i), 6'd0);
    wait_drained();

    for (int p = 0; p < 5; p++) begin
      write_reg(drrip_pkg::REG_DECAY, {27'd0, decay_set[p]});
      write_reg(drrip_pkg::REG_BRRIP, {28'd0, brrip_set[p]});
      if (p == 2) hold_request = 1;
      random_phase(PHASE_ITEMS);
      wait_drained();
    end

    repeat (30) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
